// File: rtl/svt3d_pkg.sv
// constants and register codes for the summed volume table block
// no dependencies
package svt3d_pkg;

	localparam int MAX_X = 64;
	localparam int MAX_Y = 64;
	localparam int MAX_Z = 32;

	localparam int XW = $clog2(MAX_X);
	localparam int YW = $clog2(MAX_Y);
	localparam int ZW = $clog2(MAX_Z);
	localparam int PW = YW + ZW;
	localparam int PLANE_DEPTH = MAX_Y * MAX_Z;

	localparam int SUM_W = 32;
	localparam int VOX_W = 8;
	localparam int SX_W = 7;
	localparam int SY_W = 7;
	localparam int SZ_W = 6;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_SIZE_X = 2'd0,
		REG_SIZE_Y = 2'd1,
		REG_SIZE_Z = 2'd2
	} reg_idx_t;

endpackage

// File: rtl/summed_volume_table_3d.sv
// streaming 3d summed volume table: byte voxels in, 32-bit inclusive prefix sums out
// depends on svt3d_pkg
//
// Voxels enter in raster order (z fastest, then y, then x) and each beat yields one
// inclusive 3d prefix sum, modulo 2^32, with tlast on the last voxel of the volume.
// The block takes one voxel per clock unless the output stalls; a voxel sits in
// stage 1, its sum in the output register. A voxel does one read-modify-write of the
// plane memory (2048 x 32) and row memory (32 x 64), both with a registered read;
// a result written back is forwarded to the next voxel when it reads the same entry.
// Sizes must be set through the register port only while the stream is idle; the
// block does not check it. A size of zero acts as one, above the maximum as maximum.
module summed_volume_table_3d
	import svt3d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// voxel stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [VOX_W-1:0]  s_tdata,   // [7:0] voxel
	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [SUM_W-1:0]  m_tdata,   // [31:0] prefix_sum
	output logic              m_tlast,   // volume_end
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// registers
	logic [SX_W-1:0] size_x_q;
	logic [SY_W-1:0] size_y_q;
	logic [SZ_W-1:0] size_z_q;
	reg_idx_t        reg_idx;
	logic            reg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign reg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SX_W'(MAX_X);
			size_y_q <= SY_W'(MAX_Y);
			size_z_q <= SZ_W'(MAX_Z);
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_SIZE_X: size_x_q <= pwdata[SX_W-1:0];
				REG_SIZE_Y: size_y_q <= pwdata[SY_W-1:0];
				REG_SIZE_Z: size_z_q <= pwdata[SZ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SIZE_X: prdata = DATA_W'(size_x_q);
			REG_SIZE_Y: prdata = DATA_W'(size_y_q);
			REG_SIZE_Z: prdata = DATA_W'(size_z_q);
			default:    prdata = '0;
		endcase
	end

	// effective sizes
	logic [SX_W-1:0] eff_x;
	logic [SY_W-1:0] eff_y;
	logic [SZ_W-1:0] eff_z;

	always_comb begin
		if (size_x_q == '0)                eff_x = SX_W'(1);
		else if (size_x_q > SX_W'(MAX_X))  eff_x = SX_W'(MAX_X);
		else                               eff_x = size_x_q;
		if (size_y_q == '0)                eff_y = SY_W'(1);
		else if (size_y_q > SY_W'(MAX_Y))  eff_y = SY_W'(MAX_Y);
		else                               eff_y = size_y_q;
		if (size_z_q == '0)                eff_z = SZ_W'(1);
		else if (size_z_q > SZ_W'(MAX_Z))  eff_z = SZ_W'(MAX_Z);
		else                               eff_z = size_z_q;
	end

	// position and running sum
	logic [XW-1:0]    pos_x_q;
	logic [YW-1:0]    pos_y_q;
	logic [ZW-1:0]    pos_z_q;
	logic [SUM_W-1:0] rsum_q;
	logic [SUM_W-1:0] rsum_new;
	logic             end_x, end_y, end_z;
	logic             accept;
	logic [PW-1:0]    pidx_new;

	assign end_z    = (SZ_W'(pos_z_q) + SZ_W'(1)) >= eff_z;
	assign end_y    = (SY_W'(pos_y_q) + SY_W'(1)) >= eff_y;
	assign end_x    = (SX_W'(pos_x_q) + SX_W'(1)) >= eff_x;
	assign rsum_new = rsum_q + SUM_W'(s_tdata);
	assign accept   = s_tvalid & s_tready;
	assign pidx_new = {pos_y_q, pos_z_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			rsum_q  <= '0;
		end else if (accept) begin
			if (!end_z) begin
				pos_z_q <= pos_z_q + ZW'(1);
				rsum_q  <= rsum_new;
			end else begin
				pos_z_q <= '0;
				rsum_q  <= '0;
				if (!end_y) begin
					pos_y_q <= pos_y_q + YW'(1);
				end else begin
					pos_y_q <= '0;
					pos_x_q <= end_x ? '0 : pos_x_q + XW'(1);
				end
			end
		end
	end

	// stage 1: memory data, forwarding, sum
	logic             valid_s1;
	logic [SUM_W-1:0] rsum_s1;
	logic             has_x_s1, has_y_s1, last_s1;
	logic [PW-1:0]    pidx_s1;
	logic [ZW-1:0]    z_s1;
	logic             fwd_p_s1, fwd_z_s1;
	logic [SUM_W-1:0] fwd_sum_s1, fwd_plane_s1;
	logic [SUM_W-1:0] plane_rd_s1;
	logic [2*SUM_W-1:0] row_rd_s1;

	logic [SUM_W-1:0] plane_term, row_term, corner_term, sum;
	logic             adv_s1;

	logic             out_valid_q;
	logic [SUM_W-1:0] out_data_q;
	logic             out_last_q;

	assign adv_s1   = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | adv_s1;

	always_comb begin
		plane_term  = '0;
		row_term    = '0;
		corner_term = '0;
		if (has_x_s1)
			plane_term = fwd_p_s1 ? fwd_sum_s1 : plane_rd_s1;
		if (has_y_s1)
			row_term = fwd_z_s1 ? fwd_sum_s1 : row_rd_s1[SUM_W-1:0];
		if (has_x_s1 && has_y_s1)
			corner_term = fwd_z_s1 ? fwd_plane_s1 : row_rd_s1[2*SUM_W-1:SUM_W];
		sum = rsum_s1 + row_term + plane_term - corner_term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_p_s1 <= 1'b0;
			fwd_z_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			fwd_p_s1 <= adv_s1 && (pidx_s1 == pidx_new);
			fwd_z_s1 <= adv_s1 && (z_s1 == pos_z_q);
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
			fwd_p_s1 <= 1'b0;
			fwd_z_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsum_s1      <= rsum_new;
			has_x_s1     <= pos_x_q != '0;
			has_y_s1     <= pos_y_q != '0;
			last_s1      <= end_x & end_y & end_z;
			pidx_s1      <= pidx_new;
			z_s1         <= pos_z_q;
			fwd_sum_s1   <= sum;
			fwd_plane_s1 <= plane_term;
		end
	end

	// plane memory: sums of the previous plane
	logic [SUM_W-1:0] plane_mem [PLANE_DEPTH];

	always_ff @(posedge clk) begin
		if (adv_s1)
			plane_mem[pidx_s1] <= sum;
		if (accept)
			plane_rd_s1 <= plane_mem[pidx_new];
	end

	// row memory: {previous-plane previous row, previous row}
	logic [2*SUM_W-1:0] row_mem [MAX_Z];

	always_ff @(posedge clk) begin
		if (adv_s1)
			row_mem[z_s1] <= {plane_term, sum};
		if (accept)
			row_rd_s1 <= row_mem[pos_z_q];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= sum;
			out_last_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// checks
	a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(fwd_p_s1 || fwd_z_s1) |-> valid_s1)
		else $error("forward flag set with empty stage 1");

	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("beat accepted while pipeline is full");

	a_wrap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_x && end_y && end_z)
			|=> (pos_x_q == '0 && pos_y_q == '0 && pos_z_q == '0 && rsum_q == '0))
		else $error("position did not restart after last voxel");

endmodule

// File: verif/summed_volume_table_3d_tb.sv
// self-checking testbench for summed_volume_table_3d: voxel stream in, prefix sums out
// depends on svt3d_pkg and the summed_volume_table_3d rtl; sums predicted in-bench
`timescale 1ns / 100ps

module summed_volume_table_3d_tb;
	import svt3d_pkg::*;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             last;
	} svt_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [VOX_W-1:0]  s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [SUM_W-1:0]  m_tdata;
	logic              m_tlast;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	summed_volume_table_3d uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic [SX_W-1:0]  cfg_x = 7'd64;
	logic [SY_W-1:0]  cfg_y = 7'd64;
	logic [SZ_W-1:0]  cfg_z = 6'd32;
	int unsigned      at_x = 0, at_y = 0, at_z = 0;
	logic [SUM_W-1:0] row_sum = '0;
	logic [SUM_W-1:0] plane_mem [PLANE_DEPTH];
	logic [SUM_W-1:0] row_mem [MAX_Z];
	logic [SUM_W-1:0] corner_mem [MAX_Z];

	logic [VOX_W-1:0] voxel_q [$];
	svt_result_t      sum_q [$];
	svt_result_t      want;
	int               voxels_queued = 0;
	int               sums_seen = 0;
	int               voxels_taken = 0;
	int               mismatches = 0;
	logic             s_took = 1'b0;
	logic             steady;

	// a stretch of traffic with no idling on either side
	assign steady = voxels_taken >= 500 && voxels_taken < 750;

	function automatic int unsigned eff_dim(input int unsigned raw, input int unsigned lim);
		if (raw == 0)
			return 1;
		if (raw > lim)
			return lim;
		return raw;
	endfunction

	function automatic svt_result_t predict_prefix_sum(input logic [VOX_W-1:0] vox);
		int unsigned      sx, sy, sz, pidx;
		logic [SUM_W-1:0] plane_t, row_t, corner_t, s;
		logic             ez, ey, ex;
		svt_result_t      r;
		sx = eff_dim(32'(cfg_x), MAX_X);
		sy = eff_dim(32'(cfg_y), MAX_Y);
		sz = eff_dim(32'(cfg_z), MAX_Z);
		pidx = at_y * MAX_Z + at_z;
		plane_t = '0;
		row_t = '0;
		corner_t = '0;
		row_sum = row_sum + SUM_W'(vox);
		if (at_x > 0)
			plane_t = plane_mem[PW'(pidx)];
		if (at_y > 0)
			row_t = row_mem[ZW'(at_z)];
		if (at_x > 0 && at_y > 0)
			corner_t = corner_mem[ZW'(at_z)];
		s = row_sum + row_t + plane_t - corner_t;
		corner_mem[ZW'(at_z)] = plane_t;
		row_mem[ZW'(at_z)] = s;
		plane_mem[PW'(pidx)] = s;
		ez = at_z + 1 >= sz;
		ey = at_y + 1 >= sy;
		ex = at_x + 1 >= sx;
		r.sum = s;
		r.last = ez && ey && ex;
		if (!ez) begin
			at_z = at_z + 1;
		end else begin
			at_z = 0;
			row_sum = '0;
			if (!ey) begin
				at_y = at_y + 1;
			end else begin
				at_y = 0;
				at_x = ex ? 0 : at_x + 1;
			end
		end
		return r;
	endfunction

	// voxel driver
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || s_took)) begin
			if (voxel_q.size() != 0 && (steady || $urandom_range(0, 99) >= 21)) begin
				s_tvalid <= 1'b1;
				s_tdata <= voxel_q.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			m_tready <= steady || $urandom_range(0, 99) >= 21;
	end

	// monitor: check result beats, predict on accepted voxel beats
	always @(posedge clk) begin
		if (arst_n) begin
			s_took <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				sums_seen++;
				if (sum_q.size() == 0) begin
					$error("result beat with no expected sum: prefix_sum %0h volume_end %0b",
						m_tdata, m_tlast);
					mismatches++;
				end else begin
					want = sum_q.pop_front();
					if (m_tdata !== want.sum) begin
						$error("prefix_sum expected %0h actual %0h", want.sum, m_tdata);
						mismatches++;
					end
					if (m_tlast !== want.last) begin
						$error("volume_end expected %0b actual %0b", want.last, m_tlast);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				voxels_taken++;
				sum_q.push_back(predict_prefix_sum(s_tdata));
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_SIZE_X: cfg_x = value[SX_W-1:0];
			REG_SIZE_Y: cfg_y = value[SY_W-1:0];
			REG_SIZE_Z: cfg_z = value[SZ_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (sums_seen != voxels_queued);
	endtask

	task automatic set_sizes(input logic [SX_W-1:0] rx, input logic [SY_W-1:0] ry,
			input logic [SZ_W-1:0] rz);
		wait_drained();
		write_reg(REG_SIZE_X, DATA_W'(rx));
		write_reg(REG_SIZE_Y, DATA_W'(ry));
		write_reg(REG_SIZE_Z, DATA_W'(rz));
	endtask

	task automatic push_voxel(input logic [VOX_W-1:0] v);
		voxel_q.push_back(v);
		voxels_queued++;
	endtask

	function automatic logic [VOX_W-1:0] rand_voxel();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '1;
		if (r < 25)
			return '0;
		return VOX_W'($urandom_range(0, 255));
	endfunction

	function automatic int unsigned rand_dim(input int unsigned width, input int unsigned lim);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return 0;
		if (r < 12)
			return $urandom_range(lim, (1 << width) - 1);
		if (r < 18)
			return lim;
		return $urandom_range(1, 5);
	endfunction

	task automatic queue_volumes(input int n);
		int total;
		total = n * eff_dim(32'(cfg_x), MAX_X) * eff_dim(32'(cfg_y), MAX_Y)
			* eff_dim(32'(cfg_z), MAX_Z);
		for (int i = 0; i < total; i++)
			push_voxel(rand_voxel());
	endtask

	initial begin
		int unsigned rx, ry, rz, vol;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// sizes of zero act as one: every voxel ends its own volume
		set_sizes(0, 0, 0);
		push_voxel(8'h00);
		push_voxel(8'hFF);
		push_voxel(8'hA5);
		push_voxel(8'h5A);
		set_sizes(2, 2, 3);
		for (int i = 0; i < 12; i++)
			push_voxel(8'hFF);

		// each axis at its maximum, and above it
		set_sizes(64, 1, 1);
		queue_volumes(1);
		set_sizes(127, 2, 1);
		queue_volumes(1);
		set_sizes(1, 64, 1);
		queue_volumes(1);
		set_sizes(2, 127, 2);
		queue_volumes(1);
		set_sizes(1, 1, 32);
		queue_volumes(2);
		set_sizes(3, 2, 63);
		queue_volumes(1);

		while (voxels_queued < 1200) begin
			do begin
				rx = rand_dim(SX_W, MAX_X);
				ry = rand_dim(SY_W, MAX_Y);
				rz = rand_dim(SZ_W, MAX_Z);
				vol = eff_dim(rx, MAX_X) * eff_dim(ry, MAX_Y) * eff_dim(rz, MAX_Z);
			end while (vol > 256);
			set_sizes(SX_W'(rx), SY_W'(ry), SZ_W'(rz));
			queue_volumes(1 + $urandom_range(0, 256 / vol));
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && sum_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

endmodule
